// ===== rtl/ta2_pkg.sv =====
// shared types, constants and rom builder for the table atan2 unit
`default_nettype none

package ta2_pkg;

  // fixed formats
  localparam int ROM_FRAC     = 30;
  localparam int SERIES_FRAC  = 40;
  localparam int RATIO_FRAC   = 16;
  localparam int SERIES_TERMS = 200;
  localparam int ANGLE_WIDTH  = 16;
  localparam int PHASE_W      = 32;

  // angle constants in Q30
  localparam logic [PHASE_W-1:0] PI_Q30         = 32'd3373259426;
  localparam logic [PHASE_W-1:0] HALF_PI_Q30    = 32'd1686629713;
  localparam logic [PHASE_W-1:0] QUARTER_PI_Q30 = 32'd843314857;

  // how a coordinate pair folds into the first octant
  typedef enum logic [2:0] {
    CLS_ZERO_Y,
    CLS_ZERO_X,
    CLS_EQUAL,
    CLS_X_MAJOR,
    CLS_Y_MAJOR
  } ta2_cls_t;

  // control that travels beside the datapath
  typedef struct packed {
    ta2_cls_t cls;
    logic     x_neg;
    logic     y_neg;
  } ta2_side_t;

  // shift-subtract division, used only for elaboration-time table fill
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], a[bi]};
      q = {q[62:0], 1'b0};
      if (r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(i/n) in Q30 from a truncated Q40 Euler series, rounded half up
  function automatic logic [ROM_FRAC-1:0] rom_word(input logic [63:0] n, input logic [63:0] i);
    logic [63:0] i2;
    logic [63:0] d;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    logic        done;
    i2   = i * i;
    d    = n * n + i2;
    term = udiv64((i * n) << SERIES_FRAC, d);
    sum  = term;
    done = 1'b0;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      if (!done) begin
        term = udiv64(term * i2, d);
        term = udiv64(term * 64'(2 * k), 64'(2 * k + 1));
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    rnd = (sum + (64'd1 << (SERIES_FRAC - ROM_FRAC - 1))) >> (SERIES_FRAC - ROM_FRAC);
    return rnd[ROM_FRAC-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ta2_fold.sv =====
// magnitude, axis detection and octant fold of one coordinate pair
`default_nettype none

module ta2_fold import ta2_pkg::*; #(
  parameter int CW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [CW-1:0] y,
  input  logic [CW-1:0] x,
  output logic          vld_r,
  output logic [CW-1:0] num_r,
  output logic [CW-1:0] den_r,
  output ta2_side_t     side_r
);

  logic [CW-1:0] ay;
  logic [CW-1:0] ax;
  logic [CW-1:0] num_nxt;
  logic [CW-1:0] den_nxt;
  ta2_side_t     side_nxt;

  // two's complement magnitudes, most negative value kept as is
  assign ay = y[CW-1] ? (~y) + CW'(1) : y;
  assign ax = x[CW-1] ? (~x) + CW'(1) : x;

  // classify and order the magnitudes
  always_comb begin
    side_nxt.x_neg = x[CW-1];
    side_nxt.y_neg = y[CW-1];
    num_nxt        = ay;
    den_nxt        = ax;
    priority if (ay == '0) begin
      side_nxt.cls = CLS_ZERO_Y;
    end else if (ax == '0) begin
      side_nxt.cls = CLS_ZERO_X;
    end else if (ax == ay) begin
      side_nxt.cls = CLS_EQUAL;
    end else if (ax > ay) begin
      side_nxt.cls = CLS_X_MAJOR;
    end else begin
      side_nxt.cls = CLS_Y_MAJOR;
      num_nxt      = ax;
      den_nxt      = ay;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    side_r <= side_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ta2_div.sv =====
// pipelined restoring divider: num*N*2^16/den, one quotient bit per stage
`default_nettype none

module ta2_div import ta2_pkg::*; #(
  parameter int CW = 16,
  parameter int N  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic [CW-1:0]                         num,
  input  logic [CW-1:0]                         den,
  input  ta2_side_t                             in_side,
  output logic                                  out_vld,
  output logic [$clog2(N)+RATIO_FRAC-1:0]       quot,
  output ta2_side_t                             out_side
);

  localparam int LB = $clog2(N);
  localparam int QW = LB + RATIO_FRAC;
  localparam int PW = CW + LB + 1;

  logic [PW-1:0] prod;
  logic          vld_r  [0:QW];
  logic [CW-1:0] rem_r  [0:QW];
  logic [QW-1:0] dvd_r  [0:QW];
  logic [QW-1:0] quo_r  [0:QW];
  logic [CW-1:0] den_r  [0:QW];
  ta2_side_t     side_r [0:QW];

  // scale the numerator; the high part seeds the remainder
  assign prod = PW'(num) * PW'(N);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= prod[LB +: CW];
    dvd_r[0]  <= {prod[LB-1:0], {RATIO_FRAC{1'b0}}};
    quo_r[0]  <= '0;
    den_r[0]  <= den;
    side_r[0] <= in_side;
  end

  // one compare and subtract per stage
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [CW:0] shl;
    logic [CW:0] sub;
    logic        ge;

    assign shl = {rem_r[s], dvd_r[s][QW-1]};
    assign sub = shl - {1'b0, den_r[s]};
    assign ge  = (shl >= {1'b0, den_r[s]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1]  <= ge ? sub[CW-1:0] : shl[CW-1:0];
      dvd_r[s+1]  <= {dvd_r[s][QW-2:0], 1'b0};
      quo_r[s+1]  <= {quo_r[s][QW-2:0], ge};
      den_r[s+1]  <= den_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_vld  = vld_r[QW];
  assign quot     = quo_r[QW];
  assign out_side = side_r[QW];

endmodule

`default_nettype wire

// ===== rtl/ta2_interp.sv =====
// arctangent table lookup and linear blend between neighbouring entries
`default_nettype none

module ta2_interp import ta2_pkg::*; #(
  parameter int N = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [$clog2(N)+RATIO_FRAC-1:0] quot,
  input  ta2_side_t                       in_side,
  output logic                            out_vld,
  output logic [ROM_FRAC-1:0]             th,
  output ta2_side_t                       out_side
);

  localparam int LB = $clog2(N);
  localparam int QW = LB + RATIO_FRAC;
  localparam int IW = $clog2(N + 1);
  localparam int MW = ROM_FRAC + RATIO_FRAC;

  logic [ROM_FRAC-1:0]   rom_w [0:N];
  logic [LB-1:0]         ipart;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_hi;
  logic [MW-1:0]         mul;

  logic                  vld1_r, vld2_r, vld3_r, vld4_r;
  logic [ROM_FRAC-1:0]   lo1_r, hi1_r, lo2_r, lo3_r, diff2_r, adj3_r, th4_r;
  logic [RATIO_FRAC-1:0] w1_r, w2_r;
  logic                  keep2_r, keep3_r;
  ta2_side_t             side1_r, side2_r, side3_r, side4_r;

  // constant table atan(i/N), i = 0..N
  for (genvar gi = 0; gi <= N; gi++) begin : g_rom
    assign rom_w[gi] = rom_word(64'(N), 64'(gi));
  end

  // integer part of the ratio picks the segment
  assign ipart  = quot[QW-1 -: LB];
  assign idx    = (IW'(ipart) >= IW'(N)) ? IW'(N - 1) : IW'(ipart);
  assign idx_hi = idx + IW'(1);
  assign mul    = MW'(diff2_r) * MW'(w2_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  // table read, slope, weighted step, sum
  always_ff @(posedge clk) begin
    lo1_r   <= rom_w[idx];
    hi1_r   <= rom_w[idx_hi];
    w1_r    <= quot[RATIO_FRAC-1:0];
    side1_r <= in_side;

    diff2_r <= hi1_r - lo1_r;
    keep2_r <= (hi1_r < lo1_r);
    lo2_r   <= lo1_r;
    w2_r    <= w1_r;
    side2_r <= side1_r;

    adj3_r  <= mul[MW-1:RATIO_FRAC];
    keep3_r <= keep2_r;
    lo3_r   <= lo2_r;
    side3_r <= side2_r;

    th4_r   <= keep3_r ? lo3_r : lo3_r + adj3_r;
    side4_r <= side3_r;
  end

  assign out_vld  = vld4_r;
  assign th       = th4_r;
  assign out_side = side4_r;

endmodule

`default_nettype wire

// ===== rtl/ta2_unfold.sv =====
// octant and quadrant unfold, rounding to the output format and sign
`default_nettype none

module ta2_unfold import ta2_pkg::*; #(
  parameter int AFB = 13
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [ROM_FRAC-1:0]    th,
  input  ta2_side_t              in_side,
  output logic                   out_vld,
  output logic [ANGLE_WIDTH-1:0] angle
);

  localparam int SHIFT = ROM_FRAC - AFB;

  logic [PHASE_W-1:0]     oct_nxt, phi_nxt;
  logic [PHASE_W:0]       rnd, rsh;
  logic [ANGLE_WIDTH-1:0] mag, angle_nxt;
  logic                   neg_nxt;

  logic                   vld1_r, vld2_r, vld3_r;
  logic [PHASE_W-1:0]     oct1_r, phi2_r;
  ta2_side_t              side1_r;
  logic                   neg2_r;
  logic [ANGLE_WIDTH-1:0] angle_r;

  // first octant angle, reflected for the y-major half
  always_comb begin
    unique case (in_side.cls)
      CLS_EQUAL:   oct_nxt = QUARTER_PI_Q30;
      CLS_Y_MAJOR: oct_nxt = HALF_PI_Q30 - PHASE_W'(th);
      default:     oct_nxt = PHASE_W'(th);
    endcase
  end

  // upper half-plane angle in [0, pi]
  always_comb begin
    neg_nxt = side1_r.y_neg && (side1_r.cls != CLS_ZERO_Y);
    unique case (side1_r.cls)
      CLS_ZERO_Y: phi_nxt = side1_r.x_neg ? PI_Q30 : '0;
      CLS_ZERO_X: phi_nxt = HALF_PI_Q30;
      default:    phi_nxt = side1_r.x_neg ? PI_Q30 - oct1_r : oct1_r;
    endcase
  end

  // round half up, then apply the sign
  assign rnd       = {1'b0, phi2_r} + ((PHASE_W + 1)'(1) << (SHIFT - 1));
  assign rsh       = rnd >> SHIFT;
  assign mag       = rsh[ANGLE_WIDTH-1:0];
  assign angle_nxt = neg2_r ? (~mag) + ANGLE_WIDTH'(1) : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    oct1_r  <= oct_nxt;
    side1_r <= in_side;
    phi2_r  <= phi_nxt;
    neg2_r  <= neg_nxt;
    angle_r <= angle_nxt;
  end

  assign out_vld = vld3_r;
  assign angle   = angle_r;

  // a positive x axis point always comes out as zero
  a_zero_y_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (vld1_r && side1_r.cls == CLS_ZERO_Y && !side1_r.x_neg) |=> ##1 (angle_r == '0))
    else $error("positive x axis did not give zero angle");

  // a lower half-plane result is never positive when it fits the field
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (vld2_r && neg2_r && (AFB <= 13)) |=> (angle_r[ANGLE_WIDTH-1] || angle_r == '0))
    else $error("negative y gave a positive angle");

  // the quadrant angle never exceeds pi
  a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (phi2_r <= PI_Q30))
    else $error("quadrant angle above pi");

endmodule

`default_nettype wire

// ===== rtl/table_atan2_unit.sv =====
// top level of the pipelined table-based four-quadrant arctangent
`default_nettype none

// Computes atan2(y, x) as a signed radian angle with ANGLE_FRAC_BITS fraction
// bits (16-bit field, +-25736 for pi at 13 bits).
// Input: a pair is transferred on each rising edge with start high and busy
// low. busy is held low, so a new pair may follow every cycle.
// Output: out_valid is high for exactly one cycle with out_angle; the receiver
// cannot hold results off, and none is needed since nothing waits inside.
// The pipeline runs through fold, divider, table blend and unfold in that order;
// the divider gives one quotient bit per stage, which sets most of its depth.
// Throughput is one pair per cycle.
// Axis cases, equal magnitudes and octant folding are resolved exactly; other
// pairs use a constant table of atan(i/N) with linear blending.
// Reset (synchronous, rst_n low) clears all valid bits; pairs in flight are
// dropped and the table needs no fill.
module table_atan2_unit import ta2_pkg::*; #(
  parameter int TABLE_ENTRIES   = 32,
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  output logic                          out_valid,
  output logic signed [ANGLE_WIDTH-1:0] out_angle
);

  localparam int QW      = $clog2(TABLE_ENTRIES) + RATIO_FRAC;
  localparam int LATENCY = 9 + QW;
  localparam int SHIFT   = ROM_FRAC - ANGLE_FRAC_BITS;
  localparam logic [63:0] HALF_RND =
    (64'(HALF_PI_Q30) + (64'd1 << (SHIFT - 1))) >> SHIFT;
  localparam logic [ANGLE_WIDTH-1:0] HALF_ANGLE = HALF_RND[ANGLE_WIDTH-1:0];

  logic                   f_vld, d_vld, i_vld;
  logic [COORD_WIDTH-1:0] f_num, f_den;
  ta2_side_t              f_side, d_side, i_side;
  logic [QW-1:0]          d_quot;
  logic [ROM_FRAC-1:0]    i_th;
  logic [ANGLE_WIDTH-1:0] u_angle;

  assign busy = 1'b0;

  // fold into the first octant
  ta2_fold #(.CW(COORD_WIDTH)) u_fold (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy),
    .y      (in_y_coord),
    .x      (in_x_coord),
    .vld_r  (f_vld),
    .num_r  (f_num),
    .den_r  (f_den),
    .side_r (f_side)
  );

  // scaled ratio
  ta2_div #(.CW(COORD_WIDTH), .N(TABLE_ENTRIES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .num      (f_num),
    .den      (f_den),
    .in_side  (f_side),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .out_side (d_side)
  );

  // table lookup and blend
  ta2_interp #(.N(TABLE_ENTRIES)) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d_vld),
    .quot     (d_quot),
    .in_side  (d_side),
    .out_vld  (i_vld),
    .th       (i_th),
    .out_side (i_side)
  );

  // unfold, round and sign
  ta2_unfold #(.AFB(ANGLE_FRAC_BITS)) u_unfold (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (i_vld),
    .th      (i_th),
    .in_side (i_side),
    .out_vld (out_valid),
    .angle   (u_angle)
  );

  assign out_angle = u_angle;

  // every result traces back to a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching transfer");

  // a transfer always yields a result after the pipeline latency
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("transfer produced no result");

  // positive y axis gives pi/2
  a_half_pi: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_x_coord == '0 && in_y_coord != '0 && !in_y_coord[COORD_WIDTH-1])
      |-> ##LATENCY (out_angle == HALF_ANGLE))
    else $error("positive y axis did not give pi/2");

endmodule

`default_nettype wire
